// File: hw/rtl/cptb_pkg.sv
// ----------------------------------------------------------------------------
// cptb_pkg
// types, constants and codes shared by the timer bank modules
// ----------------------------------------------------------------------------
`default_nettype none

package cptb_pkg;

  localparam int NUM_TIMERS = 4;
  localparam int CNT_W      = 16;
  localparam int TICK_W     = 11;
  localparam int CYC_W      = 10;
  localparam int IDX_W      = 2;
  localparam int REM_W      = 11;

  // control word bit positions
  localparam int CTL_PS_LO   = 0;
  localparam int CTL_PS_HI   = 1;
  localparam int CTL_CASCADE = 2;
  localparam int CTL_IRQ     = 6;
  localparam int CTL_ENABLE  = 7;

  typedef enum logic [1:0] {
    CMD_ADVANCE = 2'd0,
    CMD_RELOAD  = 2'd1,
    CMD_CONTROL = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PS_1    = 2'd0,
    PS_64   = 2'd1,
    PS_256  = 2'd2,
    PS_1024 = 2'd3
  } ps_sel_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // register writes from the top level to one cell
  typedef struct packed {
    logic             reload_we;
    logic             ctrl_we;
    logic [CNT_W-1:0] value;
  } cell_wr_t;

  // token handed from cell to cell during an advance
  typedef struct packed {
    logic                  valid;
    logic [CYC_W-1:0]      cycles;
    logic [TICK_W-1:0]     wraps;
    logic                  casc_ok;
    logic [NUM_TIMERS-1:0] mask;
  } link_t;

endpackage

`default_nettype wire

// File: hw/rtl/cptb_cell.sv
// ----------------------------------------------------------------------------
// cptb_cell
// one 16-bit reload timer with prescaler, one wrap per cycle during an advance
// ----------------------------------------------------------------------------
`default_nettype none

module cptb_cell (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire cptb_pkg::cell_wr_t              wr,
  input  wire cptb_pkg::link_t                 link_in,
  output cptb_pkg::link_t                      link_out,
  output logic [cptb_pkg::CNT_W-1:0]           count
);

  logic [cptb_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [cptb_pkg::CNT_W-1:0]      reload_r, reload_nxt;
  logic [cptb_pkg::CNT_W-1:0]      ctrl_r, ctrl_nxt;
  logic [cptb_pkg::REM_W-1:0]      rem_r, rem_nxt;
  logic                            busy_r, busy_nxt;
  logic [cptb_pkg::TICK_W-1:0]     n_r, n_nxt;
  logic [cptb_pkg::TICK_W-1:0]     wraps_r, wraps_nxt;
  logic [cptb_pkg::CYC_W-1:0]      cyc_r, cyc_nxt;
  logic [cptb_pkg::NUM_TIMERS-1:0] mask_r, mask_nxt;
  cptb_pkg::link_t                 tok_r, tok_nxt;

  logic [cptb_pkg::REM_W-1:0]      acc;
  logic [cptb_pkg::TICK_W-1:0]     ps_ticks;
  logic [cptb_pkg::REM_W-1:0]      ps_rem;
  logic [cptb_pkg::CNT_W:0]        room;
  logic                            use_casc;
  logic                            hit;

  always_comb begin
    acc = rem_r + cptb_pkg::REM_W'(link_in.cycles);
    case (cptb_pkg::ps_sel_t'(ctrl_r[cptb_pkg::CTL_PS_HI:cptb_pkg::CTL_PS_LO]))
      cptb_pkg::PS_1: begin
        ps_ticks = acc;
        ps_rem   = '0;
      end
      cptb_pkg::PS_64: begin
        ps_ticks = acc >> 6;
        ps_rem   = acc & cptb_pkg::REM_W'(63);
      end
      cptb_pkg::PS_256: begin
        ps_ticks = acc >> 8;
        ps_rem   = acc & cptb_pkg::REM_W'(255);
      end
      cptb_pkg::PS_1024: begin
        ps_ticks = acc >> 10;
        ps_rem   = acc & cptb_pkg::REM_W'(1023);
      end
      default: begin
        ps_ticks = acc;
        ps_rem   = '0;
      end
    endcase
  end

  assign room     = (cptb_pkg::CNT_W+1)'(1 << cptb_pkg::CNT_W) - {1'b0, count_r};
  assign use_casc = ctrl_r[cptb_pkg::CTL_CASCADE] && link_in.casc_ok;
  assign hit      = ctrl_r[cptb_pkg::CTL_IRQ] && (wraps_r != '0);

  always_comb begin
    count_nxt     = count_r;
    reload_nxt    = reload_r;
    ctrl_nxt      = ctrl_r;
    rem_nxt       = rem_r;
    busy_nxt      = busy_r;
    n_nxt         = n_r;
    wraps_nxt     = wraps_r;
    cyc_nxt       = cyc_r;
    mask_nxt      = mask_r;
    tok_nxt       = tok_r;
    tok_nxt.valid = 1'b0;

    if (wr.reload_we) begin
      reload_nxt = wr.value;
    end
    if (wr.ctrl_we) begin
      ctrl_nxt = wr.value;
      if (!ctrl_r[cptb_pkg::CTL_ENABLE] && wr.value[cptb_pkg::CTL_ENABLE]) begin
        count_nxt = reload_r;
        rem_nxt   = '0;
      end
    end

    if (link_in.valid) begin
      cyc_nxt  = link_in.cycles;
      mask_nxt = link_in.mask;
      if (!ctrl_r[cptb_pkg::CTL_ENABLE]) begin
        tok_nxt.valid   = 1'b1;
        tok_nxt.cycles  = link_in.cycles;
        tok_nxt.wraps   = '0;
        tok_nxt.casc_ok = 1'b1;
        tok_nxt.mask    = {1'b0, link_in.mask[cptb_pkg::NUM_TIMERS-1:1]};
      end else begin
        busy_nxt  = 1'b1;
        wraps_nxt = '0;
        if (use_casc) begin
          n_nxt = link_in.wraps;
        end else begin
          n_nxt   = ps_ticks;
          rem_nxt = ps_rem;
        end
      end
    end

    // one wrap per cycle until the remaining ticks fit below the top
    if (busy_r) begin
      if ((cptb_pkg::CNT_W+1)'(n_r) < room) begin
        count_nxt       = count_r + cptb_pkg::CNT_W'(n_r);
        busy_nxt        = 1'b0;
        tok_nxt.valid   = 1'b1;
        tok_nxt.cycles  = cyc_r;
        tok_nxt.wraps   = wraps_r;
        tok_nxt.casc_ok = 1'b1;
        tok_nxt.mask    = {hit, mask_r[cptb_pkg::NUM_TIMERS-1:1]};
      end else begin
        n_nxt     = n_r - room[cptb_pkg::TICK_W-1:0];
        wraps_nxt = wraps_r + cptb_pkg::TICK_W'(1);
        count_nxt = reload_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      reload_r  <= '0;
      ctrl_r    <= '0;
      rem_r     <= '0;
      busy_r    <= 1'b0;
      tok_r     <= '0;
    end else begin
      count_r   <= count_nxt;
      reload_r  <= reload_nxt;
      ctrl_r    <= ctrl_nxt;
      rem_r     <= rem_nxt;
      busy_r    <= busy_nxt;
      tok_r     <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    wraps_r <= wraps_nxt;
    cyc_r   <= cyc_nxt;
    mask_r  <= mask_nxt;
  end

  assign link_out = tok_r;
  assign count    = count_r;

endmodule

`default_nettype wire

// File: hw/rtl/cascadable_prescaled_timer_bank.sv
// ----------------------------------------------------------------------------
// cascadable_prescaled_timer_bank
// four cascadable 16-bit prescaled reload timers driven by a command stream
// ----------------------------------------------------------------------------
// in_*: one command word per item (advance, write reload, write control,
//   read counter); out_*: one result word per command (read data, irq mask).
// writes and reads: the result is registered in the cycle after acceptance.
// advance: a token walks the chain of timer cells in index order; a disabled
//   cell passes it on through its token register, an enabled cell first
//   registers its tick count, then runs its per-wrap loop until the remaining
//   ticks fit below the top and passes it on; the last token sets the result.
// one command is in flight at a time; the next is taken once the chain is
//   idle and the result register is empty or being drained.
// a result waits in the output register while out_tready is low; no new
//   command is accepted until it is taken.
// reset clears all counters, reload values, control words and prescale
//   remainders; the block accepts commands in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cascadable_prescaled_timer_bank (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // timer_index[1:0], write_value[17:2], cycle_count[27:18]
  input  wire logic [1:0]  in_tuser,   // cmd[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // read_data[15:0], irq_mask[19:16]
);

  localparam int N = cptb_pkg::NUM_TIMERS;

  cptb_pkg::state_t               state_r, state_nxt;
  cptb_pkg::cmd_t                 cmd;
  logic [cptb_pkg::IDX_W-1:0]     idx;
  logic [cptb_pkg::CNT_W-1:0]     wval;
  logic [cptb_pkg::CYC_W-1:0]     cyc;
  logic                           accept;
  logic                           start;

  cptb_pkg::cell_wr_t             wr     [N];
  cptb_pkg::link_t                link   [N+1];
  logic [cptb_pkg::CNT_W-1:0]     counts [N];
  logic [cptb_pkg::CNT_W-1:0]     rd_sel;

  logic                           out_valid_r, out_valid_nxt;
  logic [cptb_pkg::CNT_W-1:0]     out_rd_r, out_rd_nxt;
  logic [N-1:0]                   out_irq_r, out_irq_nxt;

  assign cmd  = cptb_pkg::cmd_t'(in_tuser);
  assign idx  = in_tdata[1:0];
  assign wval = in_tdata[17:2];
  assign cyc  = in_tdata[27:18];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cptb_pkg::ST_IDLE: begin
        if (accept && (cmd == cptb_pkg::CMD_ADVANCE)) begin
          state_nxt = cptb_pkg::ST_RUN;
        end
      end
      cptb_pkg::ST_RUN: begin
        if (link[N].valid) begin
          state_nxt = cptb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cptb_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    case (state_r)
      cptb_pkg::ST_IDLE: in_tready = !out_valid_r || out_tready;
      cptb_pkg::ST_RUN:  in_tready = 1'b0;
      default:           in_tready = 1'b0;
    endcase
  end

  assign accept = in_tvalid && in_tready;
  assign start  = accept && (cmd == cptb_pkg::CMD_ADVANCE);

  always_comb begin
    link[0].valid   = start;
    link[0].cycles  = cyc;
    link[0].wraps   = '0;
    link[0].casc_ok = 1'b0;
    link[0].mask    = '0;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    always_comb begin
      wr[i].value     = wval;
      wr[i].reload_we = accept && (cmd == cptb_pkg::CMD_RELOAD) && (int'(idx) == i);
      wr[i].ctrl_we   = accept && (cmd == cptb_pkg::CMD_CONTROL) && (int'(idx) == i);
    end

    cptb_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr       (wr[i]),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .count    (counts[i])
    );
  end

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < N; i++) begin
      if (int'(idx) == i) begin
        rd_sel = counts[i];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rd_nxt    = out_rd_r;
    out_irq_nxt   = out_irq_r;
    if (accept && (cmd != cptb_pkg::CMD_ADVANCE)) begin
      out_valid_nxt = 1'b1;
      out_rd_nxt    = (cmd == cptb_pkg::CMD_READ) ? rd_sel : '0;
      out_irq_nxt   = '0;
    end else if (link[N].valid) begin
      out_valid_nxt = 1'b1;
      out_rd_nxt    = '0;
      out_irq_nxt   = link[N].mask;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cptb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rd_r  <= out_rd_nxt;
    out_irq_r <= out_irq_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_irq_r, out_rd_r};

endmodule

`default_nettype wire

// File: hw/rtl/cptb_checker.sv
// ----------------------------------------------------------------------------
// cptb_checker
// port-level checks for the timer bank, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module cptb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [1:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result word changed while stalled");

  // no command taken while a result is stuck in the output register
  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || out_tready))
    else $error("command accepted with output register full");

  // a write or read gives its result in the next cycle with no interrupt bits
  a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser != cptb_pkg::CMD_ADVANCE))
      |=> (out_tvalid && (out_tdata[19:16] == 4'd0)))
    else $error("missing or wrong result for a write or read");

  // an advance holds off input and leaves the output empty straight after it is taken
  a_advance_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == cptb_pkg::CMD_ADVANCE))
      |=> (!in_tready && !out_tvalid))
    else $error("advance did not hold off input");

endmodule

bind cascadable_prescaled_timer_bank cptb_checker u_cptb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: tb/tb_cascadable_prescaled_timer_bank.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cascadable_prescaled_timer_bank
// self-checking stream test of the four-timer cascadable reload timer bank
// ----------------------------------------------------------------------------
// commands go in as bursts with random gaps while the result side stalls on
// its own pattern. every accepted command is run through a local model of
// the bank (counters, reload values, control words, prescale remainders)
// and the expected read data and irq mask are queued. each result word is
// compared against the oldest queued entry. directed tests cover reset
// state, enable reload, all prescale settings, cascading and irq masking,
// then random command sequences run with a full drain partway through.
// ----------------------------------------------------------------------------
module tb_cascadable_prescaled_timer_bank;

  localparam int unsigned CYCLE_LIMIT = 60_000_000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [15:0] rd;
    logic [3:0]  irq;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // timer_index[1:0], write_value[17:2], cycle_count[27:18]
  logic [1:0]  in_tuser = '0;   // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // read_data[15:0], irq_mask[19:16]

  // model state of the bank
  logic [15:0] timer_cnt    [cptb_pkg::NUM_TIMERS];
  logic [15:0] timer_reload [cptb_pkg::NUM_TIMERS];
  logic [15:0] timer_ctl    [cptb_pkg::NUM_TIMERS];
  logic [10:0] timer_rem    [cptb_pkg::NUM_TIMERS];

  timer_result_t result_q[$];
  int unsigned   mismatches = 0;
  int unsigned   items_sent = 0;
  int unsigned   burst_left = 0;
  int unsigned   cycle_cnt = 0;
  int unsigned   stall_mode = 0;

  cascadable_prescaled_timer_bank i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] make_ctl(cptb_pkg::ps_sel_t ps, logic casc, logic irq,
                                           logic en);
    logic [15:0] w;
    w = '0;
    w[cptb_pkg::CTL_PS_HI:cptb_pkg::CTL_PS_LO] = ps;
    w[cptb_pkg::CTL_CASCADE] = casc;
    w[cptb_pkg::CTL_IRQ] = irq;
    w[cptb_pkg::CTL_ENABLE] = en;
    return w;
  endfunction

  // one command applied to the model bank, returns the expected result word
  function automatic timer_result_t bank_step(cptb_pkg::cmd_t op, logic [1:0] idx,
                                              logic [15:0] val, logic [9:0] cyc);
    timer_result_t r;
    int unsigned prev_wraps;
    int unsigned wraps;
    int unsigned ticks;
    int unsigned period;
    int unsigned acc;
    int unsigned room;
    r = '0;
    case (op)
      cptb_pkg::CMD_ADVANCE: begin
        prev_wraps = 0;
        for (int t = 0; t < cptb_pkg::NUM_TIMERS; t++) begin
          wraps = 0;
          if (timer_ctl[t][cptb_pkg::CTL_ENABLE]) begin
            if (timer_ctl[t][cptb_pkg::CTL_CASCADE] && t > 0) begin
              ticks = prev_wraps;
            end else begin
              case (cptb_pkg::ps_sel_t'(timer_ctl[t][cptb_pkg::CTL_PS_HI:cptb_pkg::CTL_PS_LO]))
                cptb_pkg::PS_1:   period = 1;
                cptb_pkg::PS_64:  period = 64;
                cptb_pkg::PS_256: period = 256;
                default:          period = 1024;
              endcase
              acc = timer_rem[t] + cyc;
              ticks = acc / period;
              timer_rem[t] = 11'(acc % period);
            end
            while (ticks > 0) begin
              room = 32'h10000 - timer_cnt[t];
              if (ticks < room) begin
                timer_cnt[t] = 16'(timer_cnt[t] + ticks);
                ticks = 0;
              end else begin
                ticks -= room;
                wraps++;
                timer_cnt[t] = timer_reload[t];
              end
            end
            if (wraps > 0 && timer_ctl[t][cptb_pkg::CTL_IRQ] && t < 4) r.irq[t] = 1'b1;
          end
          prev_wraps = wraps;
        end
      end
      cptb_pkg::CMD_RELOAD: timer_reload[idx] = val;
      cptb_pkg::CMD_CONTROL: begin
        if (!timer_ctl[idx][cptb_pkg::CTL_ENABLE] && val[cptb_pkg::CTL_ENABLE]) begin
          timer_cnt[idx] = timer_reload[idx];
          timer_rem[idx] = '0;
        end
        timer_ctl[idx] = val;
      end
      default: r.rd = timer_cnt[idx];
    endcase
    return r;
  endfunction

  // called and returns at a falling edge
  task automatic send_word(input cptb_pkg::cmd_t op, input logic [1:0] idx,
                           input logic [15:0] val, input logic [9:0] cyc);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {4'b0, cyc, val, idx};
    do @(posedge clk); while (!in_tready);
    result_q.push_back(bank_step(op, idx, val, cyc));
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    burst_left = 0;
    while (result_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_reset_state();
    for (int t = 0; t < cptb_pkg::NUM_TIMERS; t++)
      send_word(cptb_pkg::CMD_READ, 2'(t), '0, '0);
    send_word(cptb_pkg::CMD_ADVANCE, '0, 16'hFFFF, 10'd1023);
  endtask

  task automatic test_enable_reload();
    send_word(cptb_pkg::CMD_RELOAD, 2'd0, 16'hFFFF, '0);
    send_word(cptb_pkg::CMD_CONTROL, 2'd0, make_ctl(cptb_pkg::PS_1, 1'b0, 1'b1, 1'b1), '0);
    send_word(cptb_pkg::CMD_READ, 2'd0, '0, '0);
    send_word(cptb_pkg::CMD_ADVANCE, '0, '0, 10'd1023);
    send_word(cptb_pkg::CMD_CONTROL, 2'd0, 16'hFFFF, 10'h3FF);
    send_word(cptb_pkg::CMD_READ, 2'd0, '0, '0);
  endtask

  task automatic test_prescale();
    send_word(cptb_pkg::CMD_RELOAD, 2'd1, 16'hFFFF, '0);
    send_word(cptb_pkg::CMD_CONTROL, 2'd1, make_ctl(cptb_pkg::PS_1024, 1'b0, 1'b1, 1'b1), '0);
    send_word(cptb_pkg::CMD_CONTROL, 2'd2, make_ctl(cptb_pkg::PS_64, 1'b0, 1'b1, 1'b1), '0);
    send_word(cptb_pkg::CMD_CONTROL, 2'd3, make_ctl(cptb_pkg::PS_256, 1'b0, 1'b1, 1'b1), '0);
    send_word(cptb_pkg::CMD_ADVANCE, '0, '0, 10'd1023);
    send_word(cptb_pkg::CMD_ADVANCE, '0, '0, 10'd1);
    send_word(cptb_pkg::CMD_ADVANCE, '0, '0, 10'd0);
    send_word(cptb_pkg::CMD_READ, 2'd2, '0, '0);
    send_word(cptb_pkg::CMD_READ, 2'd3, '0, '0);
  endtask

  task automatic test_cascade();
    // cascade bit on timer zero must be ignored
    send_word(cptb_pkg::CMD_CONTROL, 2'd0, make_ctl(cptb_pkg::PS_1, 1'b1, 1'b1, 1'b1), '0);
    send_word(cptb_pkg::CMD_CONTROL, 2'd1, make_ctl(cptb_pkg::PS_1, 1'b1, 1'b1, 1'b1), '0);
    send_word(cptb_pkg::CMD_ADVANCE, '0, '0, 10'd700);
    send_word(cptb_pkg::CMD_READ, 2'd1, '0, '0);
    // cascade from a disabled timer gets no ticks
    send_word(cptb_pkg::CMD_CONTROL, 2'd0, make_ctl(cptb_pkg::PS_1, 1'b1, 1'b1, 1'b0), '0);
    send_word(cptb_pkg::CMD_ADVANCE, '0, '0, 10'd1023);
    send_word(cptb_pkg::CMD_READ, 2'd1, '0, '0);
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned target;
    int unsigned steps;
    logic [1:0]  t;
    logic [15:0] rl;
    logic [15:0] cw;
    logic [9:0]  cyc;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) < 8) begin
        t = 2'($urandom);
        case ($urandom_range(0, 3))
          0: rl = 16'($urandom);
          1: rl = 16'($urandom_range(16'hFFF0, 16'hFFFF));
          default: rl = 16'($urandom_range(16'hFC00, 16'hFFFF));
        endcase
        send_word(cptb_pkg::CMD_RELOAD, t, rl, 10'($urandom));
        cw = 16'($urandom);
        cw[cptb_pkg::CTL_ENABLE]  = ($urandom_range(0, 9) < 8);
        cw[cptb_pkg::CTL_CASCADE] = ($urandom_range(0, 9) < 4);
        cw[cptb_pkg::CTL_IRQ]     = ($urandom_range(0, 9) < 7);
        if ($urandom_range(0, 2) == 0)
          send_word(cptb_pkg::CMD_CONTROL, t, 16'($urandom) & ~16'h0080, 10'($urandom));
        send_word(cptb_pkg::CMD_CONTROL, t, cw, 10'($urandom));
        steps = $urandom_range(2, 8);
        repeat (steps) begin
          cyc = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 15)) : 10'($urandom);
          if ($urandom_range(0, 2) == 0)
            send_word(cptb_pkg::CMD_READ, 2'($urandom), 16'($urandom), cyc);
          else
            send_word(cptb_pkg::CMD_ADVANCE, 2'($urandom), 16'($urandom), cyc);
        end
      end else begin
        send_word(cptb_pkg::cmd_t'($urandom_range(0, 3)), 2'($urandom), 16'($urandom),
                  10'($urandom));
      end
    end
  endtask

  // result side stall pattern, switching between randomly chosen modes
  always @(negedge clk) begin
    if (cycle_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 0);
      2: out_tready <= (cycle_cnt % 4 == 0);
      default: out_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    timer_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: read_data %h irq_mask %h",
                   out_tdata[15:0], out_tdata[19:16]);
      end else begin
        exp_r = result_q.pop_front();
        if (out_tdata[15:0] !== exp_r.rd || out_tdata[19:16] !== exp_r.irq) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: read_data exp %h got %h, irq_mask exp %h got %h",
                     exp_r.rd, out_tdata[15:0], exp_r.irq, out_tdata[19:16]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int t = 0; t < cptb_pkg::NUM_TIMERS; t++) begin
      timer_cnt[t] = '0;
      timer_reload[t] = '0;
      timer_ctl[t] = '0;
      timer_rem[t] = '0;
    end
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_reset_state();
    test_enable_reload();
    test_prescale();
    test_cascade();
    test_random(600);
    wait_drained();
    test_random(650);
    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
